// ===== hdl/gpioei_pkg.sv =====
// Shared types, codes and mask helpers for the GPIO port with edge interrupts.
// Used by gpioei_core, gpioei_outbuf and gpio_port_with_edge_interrupts.
// Depends on nothing.
`default_nettype none

package gpioei_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } gpioei_kind_e;

  // Register numbering of the port.
  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_OTYPE    = 4'd1,
    REG_SPEED    = 4'd2,
    REG_PULL     = 4'd3,
    REG_INPUT    = 4'd4,
    REG_OUTPUT   = 4'd5,
    REG_SETRESET = 4'd6,
    REG_AFL      = 4'd7,
    REG_AFH      = 4'd8,
    REG_MASK     = 4'd9,
    REG_RISE     = 4'd10,
    REG_FALL     = 4'd11,
    REG_PENDING  = 4'd12
  } gpioei_reg_e;

  localparam int unsigned PinsMax   = 16;
  localparam int unsigned WordWidth = 32;

  // One result item as it travels from the core to the output buffer.
  typedef struct packed {
    logic [WordWidth-1:0] read_data;
    logic [PinsMax-1:0]   out_levels;
    logic                 irq;
  } gpioei_result_t;

  // Word with the low n bits set; saturates at a full word.
  function automatic logic [WordWidth-1:0] low_ones(input int unsigned n);
    logic [WordWidth:0] full;
    full = '1;
    if (n >= WordWidth) begin
      return full[WordWidth-1:0];
    end
    return full[WordWidth-1:0] >> (WordWidth - n);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gpioei_core.sv =====
// Register state of the GPIO port and the combinational update for one item.
// Depends on gpioei_pkg.
`default_nettype none

module gpioei_core
  import gpioei_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           reg_index_i,
  input  logic [31:0]          write_data_i,
  input  logic [15:0]          pin_levels_i,
  output gpioei_result_t       result_o
);

  // Masks for bits that belong to existing pins.
  localparam logic [WordWidth-1:0] PairMaskW = low_ones(2 * PIN_COUNT);
  localparam logic [WordWidth-1:0] PinMaskW  = low_ones(PIN_COUNT);
  localparam logic [WordWidth-1:0] AflMaskW  =
    low_ones(4 * ((PIN_COUNT < 8) ? PIN_COUNT : 8));
  localparam logic [WordWidth-1:0] AfhMaskW  =
    low_ones(4 * ((PIN_COUNT > 8) ? (PIN_COUNT - 8) : 0));
  localparam logic [PinsMax-1:0]   PinMask   = PinMaskW[PinsMax-1:0];

  logic [31:0] mode_q, mode_d, speed_q, speed_d, pull_q, pull_d;
  logic [31:0] afl_q, afl_d, afh_q, afh_d;
  logic [15:0] otype_q, otype_d, input_q, input_d, output_q, output_d;
  logic [15:0] mask_q, mask_d, rise_q, rise_d, fall_q, fall_d;
  logic [15:0] pending_q, pending_d;

  logic [15:0] wr_pins, wr_high, tick_pins, rose, fell;
  logic [31:0] rd_word;

  assign wr_pins   = write_data_i[15:0] & PinMask;
  assign wr_high   = write_data_i[31:16] & PinMask;
  assign tick_pins = pin_levels_i & PinMask;
  assign rose      = tick_pins & ~input_q;
  assign fell      = input_q & ~tick_pins;

  // Register read multiplexer; write-only and unknown registers read as zero.
  always_comb begin
    unique case (gpioei_reg_e'(reg_index_i))
      REG_MODE:    rd_word = mode_q;
      REG_OTYPE:   rd_word = {16'h0000, otype_q};
      REG_SPEED:   rd_word = speed_q;
      REG_PULL:    rd_word = pull_q;
      REG_INPUT:   rd_word = {16'h0000, input_q};
      REG_OUTPUT:  rd_word = {16'h0000, output_q};
      REG_AFL:     rd_word = afl_q;
      REG_AFH:     rd_word = afh_q;
      REG_MASK:    rd_word = {16'h0000, mask_q};
      REG_RISE:    rd_word = {16'h0000, rise_q};
      REG_FALL:    rd_word = {16'h0000, fall_q};
      REG_PENDING: rd_word = {16'h0000, pending_q};
      default:     rd_word = '0;
    endcase
  end

  // Next state and result for the item being accepted.
  always_comb begin
    mode_d    = mode_q;
    otype_d   = otype_q;
    speed_d   = speed_q;
    pull_d    = pull_q;
    afl_d     = afl_q;
    afh_d     = afh_q;
    input_d   = input_q;
    output_d  = output_q;
    mask_d    = mask_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    pending_d = pending_q;
    result_o.read_data = '0;

    unique case (gpioei_kind_e'(kind_i))
      KIND_READ: begin
        result_o.read_data = rd_word;
      end
      KIND_WRITE: begin
        unique case (gpioei_reg_e'(reg_index_i))
          REG_MODE:     mode_d    = write_data_i & PairMaskW;
          REG_OTYPE:    otype_d   = wr_pins;
          REG_SPEED:    speed_d   = write_data_i & PairMaskW;
          REG_PULL:     pull_d    = write_data_i & PairMaskW;
          REG_OUTPUT:   output_d  = wr_pins;
          // Set wins over clear for the same pin.
          REG_SETRESET: output_d  = (output_q & ~wr_high) | wr_pins;
          REG_AFL:      afl_d     = write_data_i & AflMaskW;
          REG_AFH:      afh_d     = write_data_i & AfhMaskW;
          REG_MASK:     mask_d    = wr_pins;
          REG_RISE:     rise_d    = wr_pins;
          REG_FALL:     fall_d    = wr_pins;
          REG_PENDING:  pending_d = pending_q & ~wr_pins;
          default: ;
        endcase
      end
      KIND_TICK: begin
        pending_d = pending_q | (rose & rise_q) | (fell & fall_q);
        input_d   = tick_pins;
      end
      default: ;
    endcase

    result_o.out_levels = output_d;
    result_o.irq        = |(pending_d & mask_d);
  end

  // State registers, updated only when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      otype_q   <= '0;
      speed_q   <= '0;
      pull_q    <= '0;
      afl_q     <= '0;
      afh_q     <= '0;
      input_q   <= '0;
      output_q  <= '0;
      mask_q    <= '0;
      rise_q    <= '0;
      fall_q    <= '0;
      pending_q <= '0;
    end else if (push_i) begin
      mode_q    <= mode_d;
      otype_q   <= otype_d;
      speed_q   <= speed_d;
      pull_q    <= pull_d;
      afl_q     <= afl_d;
      afh_q     <= afh_d;
      input_q   <= input_d;
      output_q  <= output_d;
      mask_q    <= mask_d;
      rise_q    <= rise_d;
      fall_q    <= fall_d;
      pending_q <= pending_d;
    end
  end

`ifndef SYNTH
  // Pending and output bits never appear on pins that do not exist.
  a_pending_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~PinMask) == '0)
    else $error("pending bit set above the pin count");

  a_output_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (output_q & ~PinMask) == '0)
    else $error("output bit set above the pin count");

  // A write of ones to the pending register clears those bits.
  a_pending_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && kind_i == KIND_WRITE && reg_index_i == REG_PENDING)
    |=> (pending_q & $past(wr_pins)) == '0)
    else $error("pending bits not cleared by a write of ones");
`endif

endmodule

`default_nettype wire

// ===== hdl/gpioei_outbuf.sv =====
// Two-entry result buffer: an output register backed by a skid register.
// Depends on gpioei_pkg.
`default_nettype none

module gpioei_outbuf
  import gpioei_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gpioei_result_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           ready_i,
  output gpioei_result_t data_o
);

  logic           head_vld_q, head_vld_d, skid_vld_q, skid_vld_d;
  gpioei_result_t head_q, head_d, skid_q, skid_d;
  logic           pop;

  assign pop     = head_vld_q && ready_i;
  assign full_o  = skid_vld_q;
  assign valid_o = head_vld_q;
  assign data_o  = head_q;

  // Fill the head first; spill into the skid register while the head stalls.
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_vld_q || pop) begin
        head_d     = data_i;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      head_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

`ifndef SYNTH
  // The skid register is used only behind a held head entry.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry without head entry");

  // An accepted item always leaves a result waiting in the next cycle.
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> head_vld_q)
    else $error("accepted item produced no result");

  // A push into a full buffer would lose an item.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("item pushed into a full buffer");
`endif

endmodule

`default_nettype wire

// ===== hdl/gpio_port_with_edge_interrupts.sv =====
// Top level of the 16-pin GPIO port with edge-detecting interrupts.
// Depends on gpioei_pkg, gpioei_core and gpioei_outbuf.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one item per
//   handshake: a bus read, a bus write or a pin-sampling tick, chosen by
//   kind_i. The output channel (out_valid_o / out_ready_i) returns exactly
//   one result item for each input item, in order: read data (zero unless
//   the item is a read), the output levels after the item, and the
//   interrupt line (pending AND mask) after the item.
//   The register update and the result are formed combinationally between
//   the input ports and the output buffer, which registers each result as
//   its item is accepted. Throughput is one item per cycle as long as
//   results are taken.
//   A two-entry output buffer lets one more item be accepted while a
//   result waits; when the receiver stalls for longer, in_ready_o drops
//   until the waiting result is taken.
//   Reset clears every register of the port and empties the output buffer.
`default_nettype none

module gpio_port_with_edge_interrupts
  import gpioei_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [15:0] out_levels_o,
  output logic        irq_o
);

  logic           push;
  logic           buf_full;
  gpioei_result_t core_result, buf_result;

  assign in_ready_o = !buf_full;
  assign push       = in_valid_i && in_ready_o;

  // Register state and per-item update.
  gpioei_core #(
    .PIN_COUNT (PIN_COUNT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .kind_i       (kind_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .pin_levels_i (pin_levels_i),
    .result_o     (core_result)
  );

  // Result register with skid entry.
  gpioei_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (core_result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (buf_result)
  );

  assign read_data_o  = buf_result.read_data;
  assign out_levels_o = buf_result.out_levels;
  assign irq_o        = buf_result.irq;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for gpio_port_with_edge_interrupts: directed and random bus
// accesses and pin ticks, with each result checked against an in-bench port predictor.
// Depends on gpioei_pkg and the gpio_port_with_edge_interrupts RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpioei_pkg::*;

  // Codes that fall outside the package enums but are still legal field values.
  localparam logic [1:0] KindUnused   = 2'd3;
  localparam logic [3:0] RegUnknownLo = 4'd13;
  localparam logic [3:0] RegUnknownHi = 4'd15;
  localparam int unsigned MaxReports  = 10;

  // One access as queued for the driver.
  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
    bit          drain_first;
  } gpio_access_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic [31:0] write_data_i = '0;
  logic [15:0] pin_levels_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic [15:0] out_levels_o;
  logic        irq_o;

  gpio_port_with_edge_interrupts u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .reg_index_i (reg_index_i),
    .write_data_i(write_data_i),
    .pin_levels_i(pin_levels_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .out_levels_o(out_levels_o),
    .irq_o       (irq_o)
  );

  gpio_access_t   pending_accesses[$];
  gpioei_result_t port_results[$];
  gpio_access_t   next_access;
  gpioei_result_t want;
  bit             sender_gap;
  int unsigned    n_accepted = 0;
  int unsigned    n_total = 1;
  int unsigned    idle_phase = 0;
  int unsigned    n_mismatches = 0;

  // Predicted port state. With all 16 pins present, no register bits are dropped.
  logic [31:0] mode_q = '0, speed_q = '0, pull_q = '0, afl_q = '0, afh_q = '0;
  logic [15:0] otype_q = '0, sample_q = '0, outdata_q = '0;
  logic [15:0] mask_q = '0, rise_q = '0, fall_q = '0, pending_q = '0;

  // Applies one access to the predicted state and returns the result it should give.
  function automatic gpioei_result_t port_predict(logic [1:0] kind, logic [3:0] idx,
                                                  logic [31:0] data, logic [15:0] pins);
    gpioei_result_t res;
    logic [15:0]    rose;
    logic [15:0]    fell;
    res = '0;
    case (kind)
      KIND_READ: begin
        case (idx)
          REG_MODE:    res.read_data = mode_q;
          REG_OTYPE:   res.read_data = {16'h0, otype_q};
          REG_SPEED:   res.read_data = speed_q;
          REG_PULL:    res.read_data = pull_q;
          REG_INPUT:   res.read_data = {16'h0, sample_q};
          REG_OUTPUT:  res.read_data = {16'h0, outdata_q};
          REG_AFL:     res.read_data = afl_q;
          REG_AFH:     res.read_data = afh_q;
          REG_MASK:    res.read_data = {16'h0, mask_q};
          REG_RISE:    res.read_data = {16'h0, rise_q};
          REG_FALL:    res.read_data = {16'h0, fall_q};
          REG_PENDING: res.read_data = {16'h0, pending_q};
          default:     res.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (idx)
          REG_MODE:     mode_q = data;
          REG_OTYPE:    otype_q = data[15:0];
          REG_SPEED:    speed_q = data;
          REG_PULL:     pull_q = data;
          REG_OUTPUT:   outdata_q = data[15:0];
          // Clear from the high half first so that a set of the same pin wins.
          REG_SETRESET: outdata_q = (outdata_q & ~data[31:16]) | data[15:0];
          REG_AFL:      afl_q = data;
          REG_AFH:      afh_q = data;
          REG_MASK:     mask_q = data[15:0];
          REG_RISE:     rise_q = data[15:0];
          REG_FALL:     fall_q = data[15:0];
          REG_PENDING:  pending_q = pending_q & ~data[15:0];
          default: ;
        endcase
      end
      KIND_TICK: begin
        rose = pins & ~sample_q;
        fell = sample_q & ~pins;
        pending_q = pending_q | (rose & rise_q) | (fell & fall_q);
        sample_q = pins;
      end
      default: ;
    endcase
    res.out_levels = outdata_q;
    res.irq = |(pending_q & mask_q);
    return res;
  endfunction

  task automatic add_access(logic [1:0] kind, logic [3:0] idx, logic [31:0] data,
                            logic [15:0] pins, bit drain = 1'b0);
    gpio_access_t a;
    a.kind = kind;
    a.reg_index = idx;
    a.write_data = data;
    a.pin_levels = pins;
    a.drain_first = drain;
    pending_accesses.push_back(a);
  endtask

  // Random data word, leaning now and then toward all zeros or all ones.
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
    n_mismatches++;
    if (n_mismatches <= MaxReports) begin
      $display("tb: mismatch on %s at %0t: expected %h, got %h",
               field, $realtime, exp_val, act_val);
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: presents queued accesses and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        port_results.push_back(port_predict(kind_i, reg_index_i, write_data_i, pin_levels_i));
        n_accepted++;
        idle_phase = (n_accepted * 3) / n_total;
      end
      if (!in_valid_i || in_ready_o) begin
        case (idle_phase)
          0:       sender_gap = ($urandom_range(99) < 31);
          1:       sender_gap = ($urandom_range(99) < 48);
          default: sender_gap = 1'b0;
        endcase
        // An access flagged to drain first waits until every result has come back.
        if (pending_accesses.size() != 0 && !sender_gap &&
            !(pending_accesses[0].drain_first && port_results.size() != 0)) begin
          next_access = pending_accesses.pop_front();
          in_valid_i   <= 1'b1;
          kind_i       <= next_access.kind;
          reg_index_i  <= next_access.reg_index;
          write_data_i <= next_access.write_data;
          pin_levels_i <= next_access.pin_levels;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and drives ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (port_results.size() == 0) begin
          note_mismatch("unexpected result read_data", '0, read_data_o);
        end else begin
          want = port_results.pop_front();
          if (read_data_o !== want.read_data) begin
            note_mismatch("read_data", want.read_data, read_data_o);
          end
          if (out_levels_o !== want.out_levels) begin
            note_mismatch("out_levels", {16'h0, want.out_levels}, {16'h0, out_levels_o});
          end
          if (irq_o !== want.irq) begin
            note_mismatch("irq", {31'h0, want.irq}, {31'h0, irq_o});
          end
        end
      end
      case (idle_phase)
        0:       out_ready_i <= ($urandom_range(99) >= 48);
        1:       out_ready_i <= ($urandom_range(99) >= 31);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned n_items;
    int unsigned scenario;
    int unsigned k;
    int unsigned reps;
    logic [3:0]  cfg_reg;
    logic [15:0] pins_now;

    // Directed: first tick after reset sees high pins as rising edges.
    add_access(KIND_WRITE, REG_RISE, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_WRITE, REG_MASK, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_TICK, REG_MODE, $urandom, 16'hFFFF);
    add_access(KIND_READ, REG_PENDING, $urandom, 16'($urandom));
    // Writing ones clears pending bits, zeros leave them.
    add_access(KIND_WRITE, REG_PENDING, 32'h0000_00FF, 16'($urandom));
    add_access(KIND_READ, REG_PENDING, $urandom, 16'($urandom));
    add_access(KIND_WRITE, REG_FALL, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_TICK, REG_MODE, $urandom, 16'h0000);
    add_access(KIND_WRITE, REG_PENDING, 32'hFFFF_FFFF, 16'($urandom));
    // The input register is read-only.
    add_access(KIND_WRITE, REG_INPUT, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_READ, REG_INPUT, $urandom, 16'($urandom));
    add_access(KIND_WRITE, REG_MODE, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_READ, REG_MODE, $urandom, 16'($urandom));
    add_access(KIND_WRITE, REG_AFL, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_WRITE, REG_AFH, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_READ, REG_AFH, $urandom, 16'($urandom));
    // Output data, then set/reset clearing everything, then set and clear together.
    add_access(KIND_WRITE, REG_OUTPUT, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_WRITE, REG_SETRESET, 32'hFFFF_0000, 16'($urandom));
    add_access(KIND_WRITE, REG_SETRESET, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_READ, REG_SETRESET, $urandom, 16'($urandom));
    // Unknown registers and the unused kind.
    add_access(KIND_WRITE, RegUnknownHi, 32'hFFFF_FFFF, 16'($urandom));
    add_access(KIND_READ, RegUnknownLo, $urandom, 16'($urandom));
    add_access(KIND_READ, RegUnknownHi, $urandom, 16'($urandom));
    add_access(KindUnused, REG_MODE, 32'hFFFF_FFFF, 16'hFFFF);
    add_access(KIND_WRITE, REG_MASK, 32'h0000_0000, 16'($urandom));

    // Random scenarios; the first one waits for the port to drain completely.
    n_items = 0;
    pins_now = '0;
    while (n_items < 1250) begin
      scenario = $urandom_range(9);
      if (scenario <= 3) begin
        // Edge interrupt flow: enables and mask, a run of ticks, then clear.
        add_access(KIND_WRITE, REG_RISE, pick_word(), 16'($urandom), n_items == 0);
        add_access(KIND_WRITE, REG_FALL, pick_word(), 16'($urandom));
        add_access(KIND_WRITE, REG_MASK, pick_word(), 16'($urandom));
        reps = $urandom_range(1, 6);
        for (k = 0; k < reps; k++) begin
          pins_now = ($urandom_range(3) == 0) ? 16'($urandom) : pins_now ^ (16'($urandom)
                     & 16'($urandom));
          add_access(KIND_TICK, 4'($urandom), $urandom, pins_now);
          if ($urandom_range(2) == 0) begin
            add_access(KIND_READ, REG_PENDING, $urandom, 16'($urandom));
          end
        end
        add_access(KIND_READ, REG_INPUT, $urandom, 16'($urandom));
        add_access(KIND_WRITE, REG_PENDING, pick_word(), 16'($urandom));
        add_access(KIND_READ, REG_PENDING, $urandom, 16'($urandom));
        n_items += 6 + 2 * reps;
      end else if (scenario <= 6) begin
        // Register write followed by a read back.
        cfg_reg = 4'($urandom_range(12));
        add_access(KIND_WRITE, cfg_reg, pick_word(), 16'($urandom), n_items == 0);
        add_access(KIND_READ, cfg_reg, $urandom, 16'($urandom));
        n_items += 2;
      end else if (scenario <= 8) begin
        // Output data and set/reset.
        add_access(KIND_WRITE, REG_OUTPUT, pick_word(), 16'($urandom), n_items == 0);
        add_access(KIND_WRITE, REG_SETRESET, pick_word(), 16'($urandom));
        add_access(KIND_WRITE, REG_SETRESET, pick_word(), 16'($urandom));
        add_access(KIND_READ, REG_OUTPUT, $urandom, 16'($urandom));
        n_items += 4;
      end else begin
        // Noise across every kind and register number.
        reps = $urandom_range(1, 8);
        for (k = 0; k < reps; k++) begin
          add_access(2'($urandom_range(3)), 4'($urandom_range(15)), pick_word(),
                     16'($urandom), (n_items == 0 && k == 0) || $urandom_range(39) == 0);
        end
        n_items += reps;
      end
    end
    n_total = pending_accesses.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_accesses.size() != 0 || in_valid_i) @(posedge clk_i);
    while (port_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== gpio_port_with_edge_interrupts.f =====
hdl/gpioei_pkg.sv
hdl/gpioei_core.sv
hdl/gpioei_outbuf.sv
hdl/gpio_port_with_edge_interrupts.sv
verif/tb.sv
